// ===== rtl/gfc_pkg.sv =====
// shared types and constants for the gif frame compositor
package gfc_pkg;

  typedef enum logic [1:0] {
    FUNC_PALETTE = 2'd0,
    FUNC_FRAME   = 2'd1,
    FUNC_PIXEL   = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;
  localparam logic [2:0] DISPOSE_RESTORE_BG = 3'd2;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } rect_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [7:0]  color_index;
    logic [23:0] color_rgb;
    logic        transparent_on;
    logic [7:0]  transparent_index;
    logic [2:0]  disposal;
    logic        first_frame;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_start;
    logic clear_step;
    logic read_issue;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_clear;
    logic clear_last;
    logic wr_busy;
  } ctrl_sts_t;

endpackage

// ===== rtl/gfc_if.sv =====
// valid/ready channel interfaces
interface gfc_in_if;
  import gfc_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;
  logic        in_canvas;
  modport source (output valid, output pixel_rgba, output in_canvas, input ready);
  modport sink   (input valid, input pixel_rgba, input in_canvas, output ready);
endinterface

interface gfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gfc_ram.sv =====
// generic single port ram with registered read
module gfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/gfc_ctrl.sv =====
// controller state machine for the compositor
module gfc_ctrl import gfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_func,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output ctrl_cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   acc;
  logic   read_hold;
  logic   out_valid_r, out_valid_nxt;

  // a read waits behind a pending pixel write and a result not yet taken
  assign read_hold = (in_func == FUNC_READ) && (sts.wr_busy || out_valid_r);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_func == FUNC_FRAME && sts.need_clear) begin
          state_nxt = ST_CLEAR;
        end else if (acc && in_func == FUNC_READ) begin
          state_nxt = ST_READ;
        end
      end
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == ST_IDLE) && !read_hold;
    out_valid       = out_valid_r;
    cmd             = '0;
    cmd.accept      = acc;
    cmd.clear_start = acc && in_func == FUNC_FRAME && sts.need_clear;
    cmd.clear_step  = (state_r == ST_CLEAR);
    cmd.read_issue  = acc && in_func == FUNC_READ;
    cmd.out_load    = (state_r == ST_READ);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (state_r == ST_READ) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !cmd.accept) else $error("accept while busy");
  a_read_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r && state_r == ST_IDLE)
    else $error("read did not present");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r) else $error("result lost");
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !out_valid_r) else $error("result overwritten");
`endif
endmodule

// ===== rtl/gfc_dp.sv =====
// datapath: palette, canvas, rectangles, cursor and clearing sweep
module gfc_dp import gfc_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       item,
  input  ctrl_cmd_t   cmd,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [8:0]  cfg_wdata,
  output ctrl_sts_t   sts,
  output logic [31:0] pixel_rgba,
  output logic        in_canvas
);
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [16:0] MAXW17 = 17'(MAX_WIDTH);
  localparam logic [16:0] MAXH17 = 17'(MAX_HEIGHT);

  logic [8:0]  cw_r, ch_r;
  rect_t       cur_r;
  logic        tr_on_r;
  logic [7:0]  tr_idx_r;
  logic [2:0]  pdisp_r;
  logic [15:0] cx_r, cy_r;
  logic [16:0] cw_s, ch_s;

  // clear sweep
  logic [16:0] sx_r, sy_r, sl_r, xe_r, ye_r;

  // pixel write pipeline (palette read is registered)
  logic          pv_r;
  logic [AW-1:0] paddr_r;
  logic          pidx_ok_r;

  // read pipeline
  logic          rd_in_r;
  logic [31:0]   rdata;
  logic [23:0]   pal_rdata;

  assign cw_s = ({8'd0, cw_r} < MAXW17) ? {8'd0, cw_r} : MAXW17;
  assign ch_s = ({8'd0, ch_r} < MAXH17) ? {8'd0, ch_r} : MAXH17;

  // frame start decision
  logic [16:0] nr, nb, pr, pb;
  logic        covers, first, pal_ok;
  assign nr = 17'(item.pos_x) + 17'(item.size_w);
  assign nb = 17'(item.pos_y) + 17'(item.size_h);
  assign pr = 17'(cur_r.left) + 17'(cur_r.width);
  assign pb = 17'(cur_r.top) + 17'(cur_r.height);
  assign covers = item.pos_x <= cur_r.left && pr <= nr &&
                  item.pos_y <= cur_r.top && pb <= nb;
  assign first = item.first_frame;

  logic [16:0] fxe, fye, fl, ft;
  always_comb begin
    if (first) begin
      fl = '0; ft = '0; fxe = cw_s; fye = ch_s;
    end else begin
      fl = 17'(cur_r.left); ft = 17'(cur_r.top);
      fxe = (pr > cw_s) ? cw_s : pr;
      fye = (pb > ch_s) ? ch_s : pb;
    end
  end

  // first frame clears the full array regardless of current size
  logic [16:0] fxe2, fye2;
  assign fxe2 = first ? MAXW17 : fxe;
  assign fye2 = first ? MAXH17 : fye;

  assign sts.need_clear = (first ||
    ((item.transparent_on || !covers) && pdisp_r == DISPOSE_RESTORE_BG)) &&
    fl < fxe2 && ft < fye2;
  assign sts.clear_last = (sx_r + 17'd1 >= xe_r) && (sy_r + 17'd1 >= ye_r);
  assign sts.wr_busy    = pv_r;

  // pixel placement
  logic [16:0] ax, ay;
  logic        pix_live, pix_wr;
  assign ax = 17'(cur_r.left) + 17'(cx_r);
  assign ay = 17'(cur_r.top) + 17'(cy_r);
  assign pix_live = cmd.accept && item.func == FUNC_PIXEL && cur_r.width != 0 &&
                    cur_r.height != 0 && cy_r < cur_r.height;
  assign pix_wr = pix_live && ax < cw_s && ay < ch_s &&
                  !(tr_on_r && item.color_index == tr_idx_r);
  assign pal_ok = 32'(item.color_index) < 32'(PALETTE_SIZE);

  // canvas port
  logic          c_we;
  logic [AW-1:0] c_addr;
  logic [31:0]   c_wdata;
  logic          rd_ok;
  assign rd_ok = 17'(item.pos_x) < cw_s && 17'(item.pos_y) < ch_s;

  always_comb begin
    c_we    = 1'b0;
    c_addr  = AW'(32'(item.pos_y) * 32'(MAX_WIDTH) + 32'(item.pos_x));
    c_wdata = '0;
    if (cmd.clear_step) begin
      c_we   = 1'b1;
      c_addr = AW'(32'(sy_r) * 32'(MAX_WIDTH) + 32'(sx_r));
    end else if (pv_r) begin
      c_we    = 1'b1;
      c_addr  = paddr_r;
      c_wdata = {pidx_ok_r ? pal_rdata : 24'd0, ALPHA_OPAQUE};
    end
  end

  gfc_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_canvas (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(rdata));

  logic          p_we;
  logic [PW-1:0] p_addr;
  assign p_we   = cmd.accept && item.func == FUNC_PALETTE && pal_ok;
  assign p_addr = PW'(item.color_index);

  gfc_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_palette (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(item.color_rgb),
    .rdata(pal_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 9'd256; ch_r <= 9'd256;
      cur_r <= '0; tr_on_r <= 1'b0; tr_idx_r <= '0; pdisp_r <= '0;
      cx_r <= '0; cy_r <= '0; pv_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_WIDTH)  cw_r <= cfg_wdata;
      if (cfg_we && cfg_idx == CFG_HEIGHT) ch_r <= cfg_wdata;
      pv_r <= pix_wr;
      if (cmd.accept && item.func == FUNC_FRAME) begin
        cur_r    <= '{item.pos_x, item.pos_y, item.size_w, item.size_h};
        tr_on_r  <= item.transparent_on;
        tr_idx_r <= item.transparent_index;
        pdisp_r  <= item.disposal;
        cx_r <= '0; cy_r <= '0;
      end else if (pix_live) begin
        if (17'(cx_r) + 17'd1 >= 17'(cur_r.width)) begin
          cx_r <= '0;
          cy_r <= cy_r + 16'd1;
        end else begin
          cx_r <= cx_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr_r   <= AW'(ay[YW-1:0] * MAX_WIDTH) + AW'(ax[XW-1:0]);
    pidx_ok_r <= pal_ok;
    if (cmd.clear_start) begin
      sx_r <= fl; sy_r <= ft; sl_r <= fl; xe_r <= fxe2; ye_r <= fye2;
    end else if (cmd.clear_step) begin
      if (sx_r + 17'd1 >= xe_r) begin
        sx_r <= sl_r; sy_r <= sy_r + 17'd1;
      end else begin
        sx_r <= sx_r + 17'd1;
      end
    end
    if (cmd.read_issue) rd_in_r <= rd_ok;
    if (cmd.out_load) begin
      pixel_rgba <= rd_in_r ? rdata : 32'd0;
      in_canvas  <= rd_in_r;
    end
  end

`ifndef SYNTHESIS
  a_clear_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> sx_r < xe_r && sy_r < ye_r) else $error("clear out of rect");
  a_no_pixel_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !pv_r) else $error("pixel write during clear");
  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.width != 0 |-> cx_r < cur_r.width) else $error("cursor past row");
`endif
endmodule

// ===== rtl/gif_frame_compositor_core.sv =====
// palette loads and pixel indices are accepted back to back while the controller is idle
// read canvas pixel: result registered from the canvas read in ST_READ, held until taken;
// no item is taken in ST_READ; a read waits behind a pixel index and for the last result
// frame start: a clear sweep, if needed, writes one cleared canvas pixel per cycle (first frame
// sweeps the whole MAX_WIDTH*MAX_HEIGHT store) through the single canvas port
// reset: synchronous active-low; canvas and palette undefined until written, sizes 256
module gif_frame_compositor_core import gfc_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int PALETTE_SIZE = 256
) (
  input logic clk,
  input logic rst_n,
  gfc_in_if.sink    in_ch,
  gfc_out_if.source out_ch,
  gfc_cfg_if.sink   cfg_ch
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  gfc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_func(in_ch.data.func),
    .out_ready(out_ch.ready), .sts(sts), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .cmd(cmd));

  gfc_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
           .PALETTE_SIZE(PALETTE_SIZE)) u_dp (
    .clk(clk), .rst_n(rst_n), .item(in_ch.data), .cmd(cmd),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_wdata(cfg_ch.data),
    .sts(sts), .pixel_rgba(out_ch.pixel_rgba), .in_canvas(out_ch.in_canvas));
endmodule

// ===== tb/tb_gif_frame_compositor_core.sv =====
// self-checking testbench for the gif frame compositor core
`timescale 1ns / 100ps

module tb_gif_frame_compositor_core;
  import gfc_pkg::*;

  localparam int CANVAS_MAX  = 256;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int NUM_ITEMS   = 800;
  localparam int ITEM_W      = $bits(item_t);

  typedef struct {
    logic [31:0] rgba;
    logic        on_canvas;
  } canvas_read_t;

  typedef struct {
    item_t        it;
    bit           typed;
    canvas_read_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  gfc_in_if  in_ch ();
  gfc_out_if out_ch ();
  gfc_cfg_if cfg_ch ();

  gif_frame_compositor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow state of the compositor
  logic [31:0] canvas_mem [CANVAS_MAX*CANVAS_MAX];
  logic [23:0] palette_mem [256];
  rect_t       last_rect;
  logic [2:0]  last_disposal;
  rect_t       frame_rect;
  logic        frame_trans_on;
  logic [7:0]  frame_trans_idx;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned screen_w;
  int unsigned screen_h;

  canvas_read_t reads_due[$];
  int unsigned  loaded_idx[$];
  bit           idx_loaded [256];

  int  n_errors;
  int  n_reads_checked;
  int  n_sent;
  int  n_frames;
  int  n_cycles;
  bit  calm_stretch;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    return (screen_w < CANVAS_MAX) ? screen_w : CANVAS_MAX;
  endfunction

  function automatic int unsigned eff_h();
    return (screen_h < CANVAS_MAX) ? screen_h : CANVAS_MAX;
  endfunction

  function automatic bit rect_covers(rect_t tgt, rect_t cov);
    int unsigned tl, tt, tw, th, cl, ct, cw, chh;
    tl = tgt.left; tt = tgt.top; tw = tgt.width; th = tgt.height;
    cl = cov.left; ct = cov.top; cw = cov.width; chh = cov.height;
    return tl <= cl && cl + cw <= tl + tw && tt <= ct && ct + chh <= tt + th;
  endfunction

  task automatic blank_rect(rect_t r);
    int unsigned xe, ye;
    xe = r.left + r.width;
    ye = r.top + r.height;
    if (xe > eff_w()) xe = eff_w();
    if (ye > eff_h()) ye = eff_h();
    for (int unsigned y = r.top; y < ye; y++)
      for (int unsigned x = r.left; x < xe; x++)
        canvas_mem[y*CANVAS_MAX + x] = '0;
  endtask

  // advance the shadow state by one accepted item
  task automatic composite_item(item_t it, output bit has_read, output canvas_read_t rd);
    rect_t       nxt;
    int unsigned ax, ay;
    has_read = 1'b0;
    rd = '{rgba: '0, on_canvas: 1'b0};
    case (func_t'(it.func))
      FUNC_PALETTE: begin
        palette_mem[it.color_index] = it.color_rgb;
      end
      FUNC_FRAME: begin
        nxt = '{left: it.pos_x, top: it.pos_y, width: it.size_w, height: it.size_h};
        last_rect = frame_rect;
        if (it.first_frame) begin
          foreach (canvas_mem[i]) canvas_mem[i] = '0;
        end else if ((it.transparent_on || !rect_covers(nxt, last_rect)) &&
                     last_disposal == DISPOSE_RESTORE_BG) begin
          blank_rect(last_rect);
        end
        frame_rect      = nxt;
        frame_trans_on  = it.transparent_on;
        frame_trans_idx = it.transparent_index;
        last_disposal   = it.disposal;
        col_pos = 0;
        row_pos = 0;
      end
      FUNC_PIXEL: begin
        if (frame_rect.width != 0 && frame_rect.height != 0 && row_pos < frame_rect.height) begin
          ax = frame_rect.left + col_pos;
          ay = frame_rect.top + row_pos;
          if (ax < eff_w() && ay < eff_h() &&
              !(frame_trans_on && it.color_index == frame_trans_idx))
            canvas_mem[ay*CANVAS_MAX + ax] = {palette_mem[it.color_index], ALPHA_OPAQUE};
          col_pos++;
          if (col_pos >= frame_rect.width) begin
            col_pos = 0;
            row_pos++;
          end
        end
      end
      default: begin
        has_read = 1'b1;
        if (it.pos_x < eff_w() && it.pos_y < eff_h())
          rd = '{rgba: canvas_mem[it.pos_y*CANVAS_MAX + it.pos_x], on_canvas: 1'b1};
      end
    endcase
  endtask

  function automatic item_t mk_item(func_t f, int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h, int unsigned ci,
                                    int unsigned rgb, bit ton, int unsigned tidx,
                                    int unsigned disp, bit ff);
    item_t it;
    it.func = f; it.pos_x = 16'(x); it.pos_y = 16'(y);
    it.size_w = 16'(w); it.size_h = 16'(h);
    it.color_index = 8'(ci); it.color_rgb = 24'(rgb); it.transparent_on = ton;
    it.transparent_index = 8'(tidx); it.disposal = 3'(disp); it.first_frame = ff;
    return it;
  endfunction

  function automatic item_t rand_item();
    return item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic bit idle_now();
    return !calm_stretch && $urandom_range(99) < 21;
  endfunction

  task automatic send_item(item_t it, bit typed = 1'b0, canvas_read_t want = '{0, 0});
    bit           has_read;
    canvas_read_t rd;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    composite_item(it, has_read, rd);
    if (it.func == FUNC_PALETTE && !idx_loaded[it.color_index]) begin
      idx_loaded[it.color_index] = 1'b1;
      loaded_idx.push_back(32'(it.color_index));
    end
    if (it.func == FUNC_FRAME) n_frames++;
    if (has_read) reads_due.push_back(typed ? want : rd);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reads_due.size() != 0) @(posedge clk);
  endtask

  // a trailing read guarantees any clear sweep has finished
  task automatic quiesce();
    send_item(mk_item(FUNC_READ, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WIDTH) screen_w = 32'(val);
    else screen_h = 32'(val);
  endtask

  function automatic int unsigned pick_index();
    return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
  endfunction

  function automatic item_t rand_read();
    item_t it;
    it = rand_item();
    it.func = FUNC_READ;
    if ($urandom_range(99) < 80 && eff_w() > 0 && eff_h() > 0) begin
      it.pos_x = 16'($urandom_range(eff_w() - 1));
      it.pos_y = 16'($urandom_range(eff_h() - 1));
    end
    return it;
  endfunction

  task automatic rand_frame_sequence();
    item_t       it;
    int unsigned npix;
    it = rand_item();
    it.func = FUNC_FRAME;
    if ($urandom_range(99) < 3) begin
      it.size_w = 16'($urandom_range(65535, 1));
      it.size_h = 16'($urandom_range(65535, 1));
    end else begin
      it.size_w = 16'($urandom_range(6, 1));
      it.size_h = 16'($urandom_range(6, 1));
    end
    if ($urandom_range(99) >= 6) begin
      it.pos_x = 16'($urandom_range(CANVAS_MAX - 1));
      it.pos_y = 16'($urandom_range(CANVAS_MAX - 1));
    end
    it.first_frame = ($urandom_range(99) < 1);
    if ($urandom_range(99) < 45) it.disposal = DISPOSE_RESTORE_BG;
    if ($urandom_range(1)) it.transparent_index = 8'(pick_index());
    send_item(it);
    npix = 32'(it.size_w) * 32'(it.size_h);
    if (npix > 40) npix = 40;
    npix += $urandom_range(2);
    for (int unsigned k = 0; k < npix; k++) begin
      item_t px;
      px = rand_item();
      px.func = FUNC_PIXEL;
      px.color_index = (it.transparent_on && $urandom_range(9) < 2) ?
                       it.transparent_index : 8'(pick_index());
      send_item(px);
      if ($urandom_range(99) < 8) send_item(rand_read());
    end
  endtask

  task automatic random_items(int unsigned count);
    int unsigned target;
    item_t       it;
    target = n_sent + count;
    while (n_sent < target) begin
      calm_stretch = ($urandom_range(99) < 10) ? ~calm_stretch : calm_stretch;
      case ($urandom_range(9))
        0: begin
          it = rand_item();
          it.func = FUNC_PALETTE;
          send_item(it);
        end
        1, 2: send_item(rand_read());
        3: begin
          it = rand_item();
          it.func = FUNC_PIXEL;
          it.color_index = 8'(pick_index());
          send_item(it);
        end
        default: rand_frame_sequence();
      endcase
    end
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm_stretch || ($urandom_range(99) >= 21);
      if (out_ch.valid && out_ch.ready) begin
        if (reads_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected transaction: rgba=%h in_canvas=%b",
                     out_ch.pixel_rgba, out_ch.in_canvas);
        end else begin
          canvas_read_t w;
          w = reads_due.pop_front();
          n_reads_checked++;
          if (out_ch.pixel_rgba !== w.rgba || out_ch.in_canvas !== w.on_canvas) begin
            n_errors++;
            if (n_errors <= 10)
              $display("read mismatch: rgba exp %h got %h, in_canvas exp %b got %b",
                       w.rgba, out_ch.pixel_rgba, w.on_canvas, out_ch.in_canvas);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   dir_tab[$];
    int unsigned sizes_w[6];
    int unsigned sizes_h[6];

    n_errors = 0; n_reads_checked = 0; n_sent = 0; n_frames = 0; n_cycles = 0;
    calm_stretch = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (canvas_mem[i]) canvas_mem[i] = '0;
    foreach (palette_mem[i]) palette_mem[i] = '0;
    foreach (idx_loaded[i]) idx_loaded[i] = 1'b0;
    last_rect = '0; frame_rect = '0; last_disposal = '0;
    frame_trans_on = 1'b0; frame_trans_idx = '0;
    col_pos = 0; row_pos = 0;
    screen_w = 256; screen_h = 256;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tab = '{
      '{mk_item(FUNC_FRAME, 0, 0, 4, 2, 0, 0, 0, 0, 2, 1), 0, '{0, 0}},
      '{mk_item(FUNC_PALETTE, 0, 0, 1, 1, 0, 24'hFFFFFF, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PALETTE, 0, 0, 1, 1, 255, 24'h000000, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PALETTE, 0, 0, 1, 1, 7, 24'h123456, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 255, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 7, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 7, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_READ, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{32'hFFFFFFFF, 1'b1}},
      '{mk_item(FUNC_READ, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{32'h000000FF, 1'b1}},
      '{mk_item(FUNC_READ, 65535, 65535, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{32'h0, 1'b0}},
      '{mk_item(FUNC_READ, 255, 255, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{32'h0, 1'b1}},
      '{mk_item(FUNC_READ, 2, 1, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      // transparent frame over a restore-to-background predecessor
      '{mk_item(FUNC_FRAME, 2, 1, 3, 1, 0, 0, 1, 7, 7, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 7, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 255, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_READ, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1, '{32'h0, 1'b1}},
      '{mk_item(FUNC_READ, 3, 1, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      // frame hanging off the canvas corner
      '{mk_item(FUNC_FRAME, 255, 65535, 65535, 65535, 0, 0, 0, 0, 2, 0), 0, '{0, 0}},
      '{mk_item(FUNC_PIXEL, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}},
      '{mk_item(FUNC_READ, 255, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, '{0, 0}}
    };
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    sizes_w = '{1, 256, 511, 0, 100, 256};
    sizes_h = '{1, 511, 256, 0, 37, 256};
    for (int p = 0; p < 6; p++) begin
      quiesce();
      write_reg(CFG_WIDTH, 9'(sizes_w[p]));
      write_reg(CFG_HEIGHT, 9'(sizes_h[p]));
      random_items(NUM_ITEMS / 6);
      if (p == 2) begin
        // hold the sender until every read has come back
        wait_drained();
        calm_stretch = 1'b0;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d transactions in %0d frames, checked %0d canvas reads",
             n_sent, n_frames, n_reads_checked);
    $display("canvas sizes swept from empty through saturated, %0d mismatches",
             n_errors);
    if (n_errors == 0 && reads_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
